### hdl/wsfse_pkg.sv
`default_nettype none

package wsfse_pkg;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } req_t;

  typedef struct packed {
    logic [7:0]  stream_byte;
    logic        byte_valid;
    logic        frame_end;
    logic        frame_begun;
    logic [31:0] frame_count;
  } rsp_t;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  localparam logic [1:0] CH_G = 2'd0;
  localparam logic [1:0] CH_R = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  localparam logic [7:0]  PATTERN_ONE  = 8'hFC;
  localparam logic [7:0]  PATTERN_ZERO = 8'hC0;
  localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;

  localparam int unsigned PIXEL_W = 24;

endpackage

`default_nettype wire

### hdl/wsfse_bank_ram.sv
`default_nettype none

module wsfse_bank_ram
  import wsfse_pkg::*;
#(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  wire logic               clk_i,
  input  wire logic               wr_en_i,
  input  wire logic [AW-1:0]      wr_addr_i,
  input  wire logic [PIXEL_W-1:0] wr_data_i,
  input  wire logic               rd_en_i,
  input  wire logic [AW-1:0]      rd_addr_i,
  output logic      [PIXEL_W-1:0] rd_data_o
);

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/ws2812_frame_stream_encoder.sv
// WS2812B frame stream encoder.
// Requests arrive on the input channel (in_valid_i, in_stall_o, in_req_i) and
// every accepted request yields exactly one response on the output channel
// (out_valid_o, out_stall_i, out_rsp_o). A request either writes one pixel,
// counts one tick, or fetches the next SPI byte of the frame while one is sent.
// One request is accepted per cycle while in_stall_o is low. A response passes
// through the read of the pixel RAM and then the output register. The pixel
// RAM holds two banks per pixel; a frame start only copies the per-pixel
// write bank selects into the read bank selects.
// When the receiver stalls, the output register holds its response and one
// further request is buffered in the read stage; only then does in_stall_o
// rise. The frame period is written through cfg_we_i and cfg_wdata_i, and
// the user must do so while the block is idle; the block does not enforce it.
// After reset all pixels read as zero through per-bank valid flags, so no
// clearing pass runs and requests are accepted right away. The period, the
// tick counter and frame count reset to zero, the stream position to pixel 0.
`default_nettype none

module ws2812_frame_stream_encoder
  import wsfse_pkg::*;
#(
  parameter int unsigned PIXELS     = 64,
  parameter int unsigned COLOR_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire req_t        in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output rsp_t             out_rsp_o
);

  localparam int unsigned PW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned BW = (COLOR_BITS > 1) ? $clog2(COLOR_BITS) : 1;
  localparam int unsigned AW = PW + 1;
  localparam logic [PW-1:0] PIX_LAST = PW'(PIXELS - 1);
  localparam logic [BW-1:0] BIT_TOP  = BW'(COLOR_BITS - 1);

  logic [15:0]       period_q;
  logic [16:0]       elapsed_q, elapsed_d, elapsed_inc;
  logic              sending_q, sending_d;
  logic [31:0]       frames_q, frames_d;
  logic [PW-1:0]     pix_q, pix_d;
  logic [1:0]        ch_q, ch_d;
  logic [BW-1:0]     bit_q, bit_d;
  logic [PIXELS-1:0] pix_sel_q, frm_sel_q;
  logic [PIXELS-1:0] vld0_q, vld1_q;

  logic              in_acc, s1_adv;
  logic              wr_en, in_range, start, fetch_go, last_byte;
  logic [10:0]       idx_ext;
  logic [PW-1:0]     wr_idx;
  logic              wr_bank, rd_bank, rd_wvld;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [PIXEL_W-1:0] wr_data, rd_data;

  logic              s1_valid_q;
  logic              s1_bvalid_q, s1_fend_q, s1_begun_q, s1_wvld_q;
  logic [31:0]       s1_count_q;
  logic [1:0]        s1_ch_q;
  logic [BW-1:0]     s1_bit_q;

  logic              out_valid_q;
  rsp_t              out_q, out_d;
  logic [PIXEL_W-1:0] word;
  logic [7:0]        chan_byte;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign idx_ext  = 11'(in_req_i.pixel_index);
  assign in_range = idx_ext < 11'(PIXELS);
  assign wr_idx   = idx_ext[PW-1:0];
  assign wr_bank  = ~frm_sel_q[wr_idx];
  assign wr_en    = in_acc && (in_req_i.operation == OP_WRITE) && in_range;
  assign wr_addr  = {wr_idx, wr_bank};
  assign wr_data  = {in_req_i.green, in_req_i.red, in_req_i.blue};

  assign elapsed_inc = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 17'd1 : elapsed_q;
  assign start = in_acc && (in_req_i.operation == OP_TICK) && (period_q != 16'd0)
                 && (elapsed_inc >= {1'b0, period_q});

  assign fetch_go  = in_acc && (in_req_i.operation == OP_FETCH) && sending_q;
  assign last_byte = (pix_q == PIX_LAST) && (ch_q == CH_B) && (bit_q == '0);
  assign rd_bank   = frm_sel_q[pix_q];
  assign rd_wvld   = rd_bank ? vld1_q[pix_q] : vld0_q[pix_q];
  assign rd_addr   = {pix_q, rd_bank};

  wsfse_bank_ram #(
    .DEPTH (2 * PIXELS),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (fetch_go),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    elapsed_d = elapsed_q;
    sending_d = sending_q;
    frames_d  = frames_q;
    pix_d     = pix_q;
    ch_d      = ch_q;
    bit_d     = bit_q;
    if (in_acc && (in_req_i.operation == OP_TICK)) begin
      elapsed_d = start ? 17'd0 : elapsed_inc;
    end
    if (start) begin
      sending_d = 1'b1;
    end
    if (fetch_go) begin
      if (last_byte) begin
        pix_d     = '0;
        ch_d      = CH_G;
        bit_d     = BIT_TOP;
        frames_d  = frames_q + 32'd1;
        sending_d = 1'b0;
      end else if (bit_q != '0) begin
        bit_d = bit_q - BW'(1);
      end else begin
        bit_d = BIT_TOP;
        if (ch_q == CH_B) begin
          ch_d  = CH_G;
          pix_d = pix_q + PW'(1);
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= '0;
      elapsed_q <= '0;
      sending_q <= 1'b0;
      frames_q  <= '0;
      pix_q     <= '0;
      ch_q      <= CH_G;
      bit_q     <= BIT_TOP;
      pix_sel_q <= '0;
      frm_sel_q <= '0;
      vld0_q    <= '0;
      vld1_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      elapsed_q <= elapsed_d;
      sending_q <= sending_d;
      frames_q  <= frames_d;
      pix_q     <= pix_d;
      ch_q      <= ch_d;
      bit_q     <= bit_d;
      if (start) begin
        frm_sel_q <= pix_sel_q;
      end
      if (wr_en) begin
        pix_sel_q[wr_idx] <= wr_bank;
        if (wr_bank) begin
          vld1_q[wr_idx] <= 1'b1;
        end else begin
          vld0_q[wr_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_bvalid_q <= fetch_go;
      s1_fend_q   <= fetch_go && last_byte;
      s1_begun_q  <= start;
      s1_count_q  <= frames_d;
      s1_ch_q     <= ch_q;
      s1_bit_q    <= bit_q;
      s1_wvld_q   <= rd_wvld;
    end
  end

  always_comb begin
    word = s1_wvld_q ? rd_data : '0;
    unique case (s1_ch_q)
      CH_G:    chan_byte = word[23:16];
      CH_R:    chan_byte = word[15:8];
      default: chan_byte = word[7:0];
    endcase
    out_d.stream_byte = '0;
    if (s1_bvalid_q) begin
      out_d.stream_byte = chan_byte[3'(s1_bit_q)] ? PATTERN_ONE : PATTERN_ZERO;
    end
    out_d.byte_valid  = s1_bvalid_q;
    out_d.frame_end   = s1_fend_q;
    out_d.frame_begun = s1_begun_q;
    out_d.frame_count = s1_count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_go && last_byte |=> !sending_q && (frames_q == $past(frames_q) + 32'd1))
    else $error("frame end did not stop sending or count the frame");

  a_snapshot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> frm_sel_q == $past(pix_sel_q))
    else $error("frame start did not take the pixel bank selects");

  a_idle_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.byte_valid |->
      (out_rsp_o.stream_byte == 8'd0) && !out_rsp_o.frame_end)
    else $error("response without a frame byte carries byte data");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled while a buffer slot was free");

  a_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_q != 2'd3)
    else $error("channel counter left its range");

endmodule

`default_nettype wire
